[hw/rtl/shl_pkg.sv]
// ----------------------------------------------------------------------------
// Lexer package
// Scan modes, token kinds, character classes and keyword table.
// ----------------------------------------------------------------------------
package shl_pkg;

   typedef enum logic [3:0] {
      M_IDLE    = 4'd0,
      M_SLASH   = 4'd1,
      M_COMMENT = 4'd2,
      M_STRING  = 4'd3,
      M_ZERO    = 4'd4,
      M_PREFIX  = 4'd5,
      M_DEC     = 4'd6,
      M_DOT     = 4'd7,
      M_FRAC    = 4'd8,
      M_IDENT   = 4'd9,
      M_WAIT    = 4'd10
   } mode_type;

   localparam logic [2:0] K_COMMENT = 3'd0;
   localparam logic [2:0] K_STRING  = 3'd1;
   localparam logic [2:0] K_NUMBER  = 3'd2;
   localparam logic [2:0] K_KEYWORD = 3'd3;
   localparam logic [2:0] K_CALL    = 3'd4;
   localparam logic [2:0] K_PLAIN   = 3'd5;

   localparam logic [15:0] LEN_MAX      = 16'hFFFF;
   localparam logic [15:0] LETTER_FLOOR = 16'h00C0;
   localparam int          N_WORDS      = 36;
   localparam int          WORD_CHARS   = 8;

   typedef struct packed {
      logic [15:0] start;
      logic [15:0] len;
      logic [2:0]  kind;
      logic        run_end;
   } token_type;

   // Keyword table, up to eight ASCII characters each, first character lowest
   typedef logic [WORD_CHARS*8-1:0] word_type;

   localparam word_type WORDS [N_WORDS] = '{
      64'h0000_0000_006C_6176, // val
      64'h0000_0000_0000_6669, // if
      64'h0000_0000_6669_6C65, // elif
      64'h0000_0000_6573_6C65, // else
      64'h0000_0065_6C69_6877, // while
      64'h0000_0000_636E_7566, // func
      64'h0000_6E72_7574_6572, // return
      64'h0000_0000_6575_7274, // true
      64'h0000_0065_736C_6166, // false
      64'h0000_0000_0064_6E61, // and
      64'h0000_0000_0000_726F, // or
      64'h0000_0000_0074_6F6E, // not
      64'h0000_0074_6E69_7270, // print
      64'h0000_0067_6E69_7262, // bring
      64'h0000_0000_0000_7075, // up
      64'h0000_0000_0072_6F66, // for
      64'h0000_0000_0000_6E69, // in
      64'h0000_006B_6165_7262, // break
      64'h6575_6E69_746E_6F63, // continue
      64'h0000_6C61_626F_6C67, // global
      64'h0000_006C_6163_6F6C, // local
      64'h0000_6863_7469_7773, // switch
      64'h0000_0000_6573_6163, // case
      64'h0074_6C75_6166_6564, // default
      64'h0000_0073_7361_6C63, // class
      64'h0000_0000_6D6F_7266, // from
      64'h0000_0000_7369_6874, // this
      64'h0000_0072_6570_7573, // super
      64'h0000_0000_0074_6E69, // int
      64'h0000_0074_616F_6C66, // float
      64'h0000_0000_006D_756E, // num
      64'h0000_0000_7261_6863, // char
      64'h0000_0000_0072_7473, // str
      64'h0000_0000_7478_6574, // text
      64'h0000_0000_0071_6573, // seq
      64'h0000_0073_6574_7962  // bytes
   };

   localparam int WORD_CLASS = 24;
   localparam int WORD_FROM  = 25;

   function automatic logic [3:0] word_len(input word_type w);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < WORD_CHARS; i++) begin
         if (w[i*8 +: 8] != 8'd0) n = 4'(i + 1);
      end
      return n;
   endfunction

   function automatic logic is_digit(input logic [15:0] c);
      return c >= 16'h30 && c <= 16'h39;
   endfunction

   function automatic logic is_letter(input logic [15:0] c);
      return (c >= 16'h41 && c <= 16'h5A) || (c >= 16'h61 && c <= 16'h7A) ||
             c == 16'h5F || c >= LETTER_FLOOR;
   endfunction

   function automatic logic is_blank(input logic [15:0] c);
      return c == 16'h20 || c == 16'h09 || c == 16'h0D || c == 16'h0A;
   endfunction

   function automatic logic [15:0] grow(input logic [15:0] l, input logic [1:0] by);
      logic [16:0] s;
      s = {1'b0, l} + 17'(by);
      return s[16] ? LEN_MAX : s[15:0];
   endfunction

   // match a held word against the table: {class or from, any keyword}
   function automatic logic [1:0] word_match(input logic [WORD_CHARS*16-1:0] w,
                                             input logic [15:0] len,
                                             input logic over);
      logic m, kw, cf;
      kw = 1'b0;
      cf = 1'b0;
      for (int k = 0; k < N_WORDS; k++) begin
         m = !over && (len == 16'(word_len(WORDS[k])));
         for (int i = 0; i < WORD_CHARS; i++) begin
            if (i < int'(word_len(WORDS[k])) &&
                w[i*16 +: 16] != {8'd0, WORDS[k][i*8 +: 8]}) m = 1'b0;
         end
         if (m) kw = 1'b1;
         if (m && (k == WORD_CLASS || k == WORD_FROM)) cf = 1'b1;
      end
      return {cf, kw};
   endfunction

endpackage

[hw/rtl/shl_scan.sv]
// ----------------------------------------------------------------------------
// Lexer front end
// Scans one character per cycle while both queue slots are free, and queues up to two tokens for it.
// ----------------------------------------------------------------------------
module shl_scan #(
   parameter int POS_BITS        = 16,
   parameter int MAX_KEYWORD_LEN = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [15:0]       in_ch,
   input  logic              in_last,
   output logic              push,
   output logic [1:0]        push_count,
   output shl_pkg::token_type push_tok [2],
   input  logic [1:0]        space
);

   localparam int WIDX = $clog2(MAX_KEYWORD_LEN);

   shl_pkg::mode_type mode_ff, mode_in;
   logic              esc_ff, esc_in, tnn_ff, tnn_in, over_ff, over_in;
   logic [POS_BITS-1:0] pos_ff, pos_in, beg_ff, beg_in;
   logic [15:0]       len_ff, len_in;
   logic [15:0]       wch_ff [MAX_KEYWORD_LEN];
   logic              wr_en;
   logic [WIDX-1:0]   wr_idx;
   logic [15:0]       c;
   logic              fire, kw_hit, cf_hit;
   logic [1:0]        n;
   logic [shl_pkg::WORD_CHARS*16-1:0] word_now;
   shl_pkg::token_type tk [2];

   assign c        = in_ch;
   assign in_ready = (space == 2'd2);
   assign fire     = in_valid && in_ready;

   // keyword matching on the held word
   always_comb begin
      for (int i = 0; i < shl_pkg::WORD_CHARS; i++) word_now[i*16 +: 16] = wch_ff[i];
      {cf_hit, kw_hit} = shl_pkg::word_match(word_now, len_ff, over_ff);
   end

   always_comb begin
      logic [POS_BITS-1:0] p;
      logic                word_call, do_word, do_idle;
      logic [2:0]          put_kind, wk;
      logic                do_put;
      logic [15:0]         put_len;
      logic [2:0]          fl_kind;
      logic                fl_put;
      logic [shl_pkg::WORD_CHARS*16-1:0] word_new;
      logic [1:0]          fm;
      p        = pos_ff;
      mode_in  = mode_ff;
      esc_in   = esc_ff;
      tnn_in   = tnn_ff;
      over_in  = over_ff;
      beg_in   = beg_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      wr_en    = 1'b0;
      wr_idx   = '0;
      do_put   = 1'b0;
      put_kind = shl_pkg::K_PLAIN;
      put_len  = len_ff;
      do_word  = 1'b0;
      word_call = 1'b0;
      do_idle  = 1'b0;
      n        = 2'd0;
      fl_put   = 1'b0;
      fl_kind  = shl_pkg::K_PLAIN;
      tk[0]    = '0;
      tk[1]    = '0;
      unique case (mode_ff)
         shl_pkg::M_SLASH: begin
            if (c == 16'h2F) begin
               mode_in = shl_pkg::M_COMMENT;
               len_in  = shl_pkg::grow(len_ff, 2'd1);
            end else begin
               tnn_in  = 1'b0;
               do_idle = 1'b1;
            end
         end
         shl_pkg::M_COMMENT: begin
            if (c == 16'h0A || c == 16'h0D) begin
               do_put = 1'b1; put_kind = shl_pkg::K_COMMENT; do_idle = 1'b1;
            end else len_in = shl_pkg::grow(len_ff, 2'd1);
         end
         shl_pkg::M_STRING: begin
            if (esc_ff) begin
               esc_in = 1'b0; len_in = shl_pkg::grow(len_ff, 2'd1);
            end else if (c == 16'h22) begin
               do_put = 1'b1; put_kind = shl_pkg::K_STRING;
               put_len = shl_pkg::grow(len_ff, 2'd1);
               mode_in = shl_pkg::M_IDLE; len_in = '0;
            end else if (c == 16'h0A || c == 16'h0D) begin
               do_put = 1'b1; put_kind = shl_pkg::K_STRING; do_idle = 1'b1;
            end else begin
               if (c == 16'h5C) esc_in = 1'b1;
               len_in = shl_pkg::grow(len_ff, 2'd1);
            end
         end
         shl_pkg::M_ZERO, shl_pkg::M_DEC: begin
            if (mode_ff == shl_pkg::M_ZERO &&
                (c == 16'h78 || c == 16'h58 || c == 16'h62 || c == 16'h42)) begin
               mode_in = shl_pkg::M_PREFIX; len_in = shl_pkg::grow(len_ff, 2'd1);
            end else begin
               mode_in = shl_pkg::M_DEC;
               if (shl_pkg::is_digit(c)) len_in = shl_pkg::grow(len_ff, 2'd1);
               else if (c == 16'h2E) mode_in = shl_pkg::M_DOT;
               else begin do_put = 1'b1; put_kind = shl_pkg::K_NUMBER; do_idle = 1'b1; end
            end
         end
         shl_pkg::M_PREFIX, shl_pkg::M_FRAC: begin
            if (mode_ff == shl_pkg::M_PREFIX ?
                (shl_pkg::is_letter(c) || shl_pkg::is_digit(c)) : shl_pkg::is_digit(c))
               len_in = shl_pkg::grow(len_ff, 2'd1);
            else begin do_put = 1'b1; put_kind = shl_pkg::K_NUMBER; do_idle = 1'b1; end
         end
         shl_pkg::M_DOT: begin
            if (shl_pkg::is_digit(c)) begin
               mode_in = shl_pkg::M_FRAC; len_in = shl_pkg::grow(len_ff, 2'd2);
            end else begin
               do_put = 1'b1; put_kind = shl_pkg::K_NUMBER; tnn_in = 1'b0; do_idle = 1'b1;
            end
         end
         shl_pkg::M_IDENT, shl_pkg::M_WAIT: begin
            if (mode_ff == shl_pkg::M_IDENT &&
                (shl_pkg::is_letter(c) || shl_pkg::is_digit(c))) begin
               if (len_ff < 16'(MAX_KEYWORD_LEN)) begin
                  wr_en = 1'b1; wr_idx = len_ff[WIDX-1:0];
               end else over_in = 1'b1;
               len_in = shl_pkg::grow(len_ff, 2'd1);
            end else if (c == 16'h20 || c == 16'h09) begin
               mode_in = shl_pkg::M_WAIT;
            end else begin
               do_word = 1'b1; word_call = (c == 16'h28); do_idle = 1'b1;
            end
         end
         default: do_idle = 1'b1;
      endcase

      wk = (tnn_ff || word_call) ? shl_pkg::K_CALL :
           (kw_hit ? shl_pkg::K_KEYWORD : shl_pkg::K_PLAIN);
      if (cf_hit) wk = shl_pkg::K_KEYWORD;
      if (do_word) begin
         do_put = 1'b1; put_kind = wk; tnn_in = cf_hit;
      end
      if (do_put) begin
         tk[0] = '{start: 16'(beg_ff), len: put_len, kind: put_kind, run_end: 1'b0};
         n = 2'd1;
      end

      if (do_idle) begin
         mode_in = shl_pkg::M_IDLE;
         beg_in  = p;
         len_in  = 16'd1;
         if (c == 16'h2F) mode_in = shl_pkg::M_SLASH;
         else if (c == 16'h22) begin mode_in = shl_pkg::M_STRING; esc_in = 1'b0; end
         else if (shl_pkg::is_digit(c))
            mode_in = (c == 16'h30) ? shl_pkg::M_ZERO : shl_pkg::M_DEC;
         else if (shl_pkg::is_letter(c)) begin
            mode_in = shl_pkg::M_IDENT; wr_en = 1'b1; wr_idx = '0; over_in = 1'b0;
         end else begin
            len_in = '0;
            if (!shl_pkg::is_blank(c)) tnn_in = 1'b0;
         end
      end

      // word as it stands after this character
      for (int i = 0; i < shl_pkg::WORD_CHARS; i++)
         word_new[i*16 +: 16] = (wr_en && wr_idx == WIDX'(i)) ? c : wch_ff[i];
      fm = shl_pkg::word_match(word_new, len_in, over_in);

      if (in_last) begin
         unique case (mode_in)
            shl_pkg::M_COMMENT: begin fl_put = 1'b1; fl_kind = shl_pkg::K_COMMENT; end
            shl_pkg::M_STRING:  begin fl_put = 1'b1; fl_kind = shl_pkg::K_STRING; end
            shl_pkg::M_ZERO, shl_pkg::M_PREFIX, shl_pkg::M_DEC, shl_pkg::M_DOT,
            shl_pkg::M_FRAC: begin fl_put = 1'b1; fl_kind = shl_pkg::K_NUMBER; end
            shl_pkg::M_IDENT, shl_pkg::M_WAIT: begin
               fl_put  = 1'b1;
               fl_kind = fm[1] ? shl_pkg::K_KEYWORD :
                         (tnn_in ? shl_pkg::K_CALL :
                          (fm[0] ? shl_pkg::K_KEYWORD : shl_pkg::K_PLAIN));
            end
            default: fl_put = 1'b0;
         endcase
         if (fl_put) begin
            tk[n[0]] = '{start: 16'(beg_in), len: len_in, kind: fl_kind, run_end: 1'b0};
            n = n + 2'd1;
         end
         mode_in = shl_pkg::M_IDLE;
         esc_in  = 1'b0; tnn_in = 1'b0; over_in = 1'b0;
         pos_in  = '0; beg_in = '0; len_in = '0;
      end else pos_in = pos_ff + 1'b1;
      if (n != 2'd0) tk[n[1]].run_end = 1'b1;
   end

   assign push       = fire && (n != 2'd0);
   assign push_count = n;
   assign push_tok   = tk;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= shl_pkg::M_IDLE;
         esc_ff  <= 1'b0;
         tnn_ff  <= 1'b0;
         over_ff <= 1'b0;
         pos_ff  <= '0;
         beg_ff  <= '0;
         len_ff  <= '0;
      end else if (fire) begin
         mode_ff <= mode_in;
         esc_ff  <= esc_in;
         tnn_ff  <= tnn_in;
         over_ff <= over_in;
         pos_ff  <= pos_in;
         beg_ff  <= beg_in;
         len_ff  <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && wr_en) wch_ff[wr_idx] <= c;
   end

endmodule

[hw/rtl/shl_queue.sv]
// ----------------------------------------------------------------------------
// Token queue
// Two-entry queue between scanner and output; takes one or two per push.
// ----------------------------------------------------------------------------
module shl_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [1:0]         push_count,
   input  shl_pkg::token_type push_tok [2],
   output logic [1:0]         space,
   output logic               out_valid,
   output shl_pkg::token_type out_tok,
   input  logic               out_ready
);

   shl_pkg::token_type q_ff [2];
   logic [1:0]         cnt_ff, cnt_in;
   logic               pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = cnt_ff != 2'd0;
   assign out_tok   = q_ff[0];
   // count the slot freed by this cycle's pop
   assign space     = 2'd2 - cnt_ff + {1'b0, pop};

   always_comb begin
      cnt_in = cnt_ff - {1'b0, pop} + (push ? push_count : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[0] <= push_tok[0];
         q_ff[1] <= push_tok[1];
      end else if (pop) begin
         q_ff[0] <= q_ff[1];
      end
   end

endmodule

[hw/rtl/syntax_highlight_lexer_unit.sv]
// ----------------------------------------------------------------------------
// Syntax highlighting lexer
// Characters in, tokens (start, length, kind) out.
// The first token a character closes is offered in the cycle after that character.
// Throughput: one character a cycle while each token is taken as it leaves;
// a character is taken when both queue slots are free, counting this cycle's pop.
// Reset: synchronous, clears scan state, position and queue.
// ----------------------------------------------------------------------------
module syntax_highlight_lexer_unit #(
   parameter int POS_BITS        = 16,
   parameter int MAX_KEYWORD_LEN = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // ch
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // tok_start, tok_len, tok_kind, zero fill
   output logic        rsp_tlast    // run_end
);

   logic               push;
   logic [1:0]         push_count, space;
   shl_pkg::token_type push_tok [2];
   shl_pkg::token_type out_tok;

   shl_scan #(.POS_BITS(POS_BITS), .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)) u_scan (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_ch(req_tdata), .in_last(req_tlast),
      .push, .push_count, .push_tok, .space
   );

   shl_queue u_queue (
      .clock, .reset, .push, .push_count, .push_tok, .space,
      .out_valid(rsp_tvalid), .out_tok, .out_ready(rsp_tready)
   );

   assign rsp_tdata = {5'd0, out_tok.kind, out_tok.len, out_tok.start};
   assign rsp_tlast = out_tok.run_end;

endmodule

[tb/sv/tb_syntax_highlight_lexer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer testbench
// Streams characters into the lexer and checks every token against a
// behavioural scanner, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_syntax_highlight_lexer_unit;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // ch
   logic        req_tlast;   // end_of_text
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // tok_start, tok_len, tok_kind, zero fill
   logic        rsp_tlast;   // run_end

   syntax_highlight_lexer_unit dut (.*);

   typedef struct packed {
      logic [15:0] start;
      logic [15:0] len;
      logic [2:0]  kind;
      logic        last;
   } tok_type;

   tok_type token_queue[$];
   int      errors = 0;
   int      send_idle = 0;
   int      recv_stall = 0;

   // scanner state
   shl_pkg::mode_type sc_mode;
   logic        sc_esc, sc_type;
   logic [15:0] sc_pos, sc_begin, sc_len;
   logic [15:0] sc_word [8];
   logic        sc_long;
   tok_type     step_out[$];

   string kw [36] = '{"val","if","elif","else","while","func","return","true","false",
      "and","or","not","print","bring","up","for","in","break","continue","global",
      "local","switch","case","default","class","from","this","super","int","float",
      "num","char","str","text","seq","bytes"};

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic report(input string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   function automatic void sc_clear();
      sc_mode = shl_pkg::M_IDLE; sc_esc = 0; sc_type = 0; sc_pos = 0; sc_begin = 0;
      sc_len = 0; sc_long = 0;
      for (int i = 0; i < 8; i++) sc_word[i] = 0;
   endfunction

   function automatic void sc_grow(input int by);
      sc_len = (int'(sc_len) + by > 65535) ? 16'hFFFF : sc_len + 16'(by);
   endfunction

   function automatic void sc_put(input logic [2:0] k);
      tok_type t;
      if (step_out.size() >= 2) return;
      t.start = sc_begin; t.len = sc_len; t.kind = k; t.last = 0;
      step_out = {step_out, t};
   endfunction

   function automatic logic word_eq(input string w);
      if (sc_long || w.len() != sc_len) return 0;
      for (int i = 0; i < w.len(); i++)
         if (sc_word[i] != 16'(w[i])) return 0;
      return 1;
   endfunction

   function automatic void sc_word_out(input logic call);
      logic [2:0] k;
      logic       cf;
      k = shl_pkg::K_PLAIN;
      if (sc_type || call) k = shl_pkg::K_CALL;
      else foreach (kw[i]) if (word_eq(kw[i])) k = shl_pkg::K_KEYWORD;
      cf = word_eq("class") || word_eq("from");
      sc_type = cf;
      if (cf) k = shl_pkg::K_KEYWORD;
      sc_put(k);
   endfunction

   function automatic void sc_idle(input logic [15:0] c);
      sc_mode = shl_pkg::M_IDLE; sc_begin = sc_pos; sc_len = 1;
      if (c == "/") sc_mode = shl_pkg::M_SLASH;
      else if (c == "\"") begin
         sc_mode = shl_pkg::M_STRING; sc_esc = 0;
      end else if (shl_pkg::is_digit(c))
         sc_mode = (c == "0") ? shl_pkg::M_ZERO : shl_pkg::M_DEC;
      else if (shl_pkg::is_letter(c)) begin
         sc_mode = shl_pkg::M_IDENT; sc_word[0] = c; sc_long = 0;
      end else begin
         sc_len = 0;
         if (!shl_pkg::is_blank(c)) sc_type = 0;
      end
   endfunction

   function automatic void sc_dec(input logic [15:0] c);
      if (shl_pkg::is_digit(c)) sc_grow(1);
      else if (c == ".") sc_mode = shl_pkg::M_DOT;
      else begin
         sc_put(shl_pkg::K_NUMBER); sc_idle(c);
      end
   endfunction

   function automatic void predict_tokens(input logic [15:0] c, input logic eot);
      step_out.delete();
      case (sc_mode)
         shl_pkg::M_SLASH: if (c == "/") begin
            sc_mode = shl_pkg::M_COMMENT; sc_grow(1);
         end else begin
            sc_type = 0; sc_idle(c);
         end
         shl_pkg::M_COMMENT: if (c == 10 || c == 13) begin
            sc_put(shl_pkg::K_COMMENT); sc_idle(c);
         end else sc_grow(1);
         shl_pkg::M_STRING: if (sc_esc) begin
            sc_esc = 0; sc_grow(1);
         end else if (c == "\"") begin
            sc_grow(1); sc_put(shl_pkg::K_STRING); sc_mode = shl_pkg::M_IDLE; sc_len = 0;
         end else if (c == 10 || c == 13) begin
            sc_put(shl_pkg::K_STRING); sc_idle(c);
         end else begin
            if (c == "\\") sc_esc = 1;
            sc_grow(1);
         end
         shl_pkg::M_ZERO: if (c == "x" || c == "X" || c == "b" || c == "B") begin
            sc_mode = shl_pkg::M_PREFIX; sc_grow(1);
         end else begin
            sc_mode = shl_pkg::M_DEC; sc_dec(c);
         end
         shl_pkg::M_PREFIX, shl_pkg::M_FRAC:
            if ((sc_mode == shl_pkg::M_PREFIX) ?
                (shl_pkg::is_letter(c) || shl_pkg::is_digit(c)) : shl_pkg::is_digit(c))
               sc_grow(1);
            else begin
               sc_put(shl_pkg::K_NUMBER); sc_idle(c);
            end
         shl_pkg::M_DEC: sc_dec(c);
         shl_pkg::M_DOT: if (shl_pkg::is_digit(c)) begin
            sc_mode = shl_pkg::M_FRAC; sc_grow(2);
         end else begin
            sc_put(shl_pkg::K_NUMBER); sc_type = 0; sc_idle(c);
         end
         shl_pkg::M_IDENT, shl_pkg::M_WAIT:
            if (sc_mode == shl_pkg::M_IDENT &&
                (shl_pkg::is_letter(c) || shl_pkg::is_digit(c))) begin
               if (sc_len < 8) sc_word[sc_len[2:0]] = c;
               else sc_long = 1;
               sc_grow(1);
            end else if (c == " " || c == 9) sc_mode = shl_pkg::M_WAIT;
            else begin
               sc_word_out(c == "(");
               sc_idle(c);
            end
         default: sc_idle(c);
      endcase
      if (eot) begin
         case (sc_mode)
            shl_pkg::M_COMMENT: sc_put(shl_pkg::K_COMMENT);
            shl_pkg::M_STRING: sc_put(shl_pkg::K_STRING);
            shl_pkg::M_ZERO, shl_pkg::M_PREFIX, shl_pkg::M_DEC, shl_pkg::M_DOT,
            shl_pkg::M_FRAC: sc_put(shl_pkg::K_NUMBER);
            shl_pkg::M_IDENT, shl_pkg::M_WAIT: sc_word_out(0);
            default: ;
         endcase
         sc_clear();
      end else sc_pos++;
      if (step_out.size() > 0) step_out[step_out.size()-1].last = 1;
      foreach (step_out[i]) token_queue = {token_queue, step_out[i]};
   endfunction

   task automatic send_char(input logic [15:0] c, input logic eot);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1; req_tdata <= c; req_tlast <= eot;
      do @(posedge clock); while (!req_tready);
      predict_tokens(c, eot);
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input logic eot);
      for (int i = 0; i < s.len(); i++) send_char(16'(s[i]), eot && i == s.len() - 1);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tok_type got, want;
         got.start = rsp_tdata[15:0];
         got.len   = rsp_tdata[31:16];
         got.kind  = rsp_tdata[34:32];
         got.last  = rsp_tlast;
         if (token_queue.size() == 0) report("token with none expected");
         else begin
            want = token_queue.pop_front();
            if (got.start != want.start) report($sformatf("start %0d want %0d",
               got.start, want.start));
            if (got.len != want.len) report($sformatf("len %0d want %0d",
               got.len, want.len));
            if (got.kind != want.kind) report($sformatf("kind %0d want %0d",
               got.kind, want.kind));
            if (got.last != want.last) report("run_end flag");
         end
      end
   end

   always @(negedge clock)
      rsp_tready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);

   function automatic logic [15:0] rand_char();
      int r;
      string set;
      r = $urandom_range(99);
      set = "abcfilmorstnvxXbB_0123456789./\"\\( \t\n\r+";
      if (r < 80) return 16'(set[$urandom_range(set.len()-1)]);
      if (r < 90) return 16'($urandom_range(16'hFFFF, 16'hC0));
      return 16'($urandom_range(16'hFFFF));
   endfunction

   task automatic test_directed();
      send_text("// note\nclass Foo from bar\n", 0);
      send_text("x = \"a\\\"b\\\nc\" + 0x1F + 0b10 + 12.5 + 3.x", 0);
      send_text(" print  (y) continue continued val\t(", 0);
      send_text("a / b \"open", 1);
      send_text("/", 1);
      send_text("9.", 1);
      send_char(16'hFFFF, 0); send_char(16'h00C0, 1);
      send_char(16'h0000, 1);
      send_text("class 7 z", 1);
   endtask

   task automatic test_random(input int n, input int si, input int rs);
      send_idle = si; recv_stall = rs;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) < 7) send_text(kw[$urandom_range(35)], 0);
         else send_char(rand_char(), $urandom_range(40) == 0);
         send_char(rand_char(), $urandom_range(30) == 0);
      end
      send_idle = 0; recv_stall = 0;
   endtask

   task automatic test_long_token();
      // overlong words, then a comment well past the keyword length
      send_text("continuex continuedandmore //", 0);
      for (int i = 0; i < 40; i++) send_char("c", 0);
      send_text("\nabcdefghij k", 1);
   endtask

   initial begin
      int wait_cycles;
      sc_clear();
      reset = 1; req_tvalid = 0; req_tdata = 0; req_tlast = 0; rsp_tready = 1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_random(30, 0, 0);
      test_random(30, 87, 0);
      test_random(30, 0, 87);
      test_random(30, 12, 12);
      test_long_token();
      send_text("x", 1);
      req_tvalid <= 0;
      wait_cycles = 0;
      while (token_queue.size() > 0 && wait_cycles < 100000) begin
         @(posedge clock); wait_cycles++;
      end
      repeat (10) @(posedge clock);
      if (errors == 0 && token_queue.size() == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
